### rtl/hct_pkg.sv
// Shared types and constants for the handheld console timer.
package hct_pkg;

    // Item operation codes.
    localparam logic [1:0] FUNC_READ  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // Register addresses on the bus.
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_STEP = 16'hFF05;
    localparam logic [15:0] ADDR_RND  = 16'hFF06;
    localparam logic [15:0] ADDR_CTRL = 16'hFF07;

    // Control register layout and the read value of an unknown address.
    localparam int          CTRL_ENABLE_BIT = 2;
    localparam logic [7:0]  READ_UNKNOWN    = 8'hFF;

    // Divider period minus one, in ticks.
    localparam logic [9:0]  DIV_PERIOD_MASK = 10'd127;

    // Rate codes of the control register.
    localparam logic [1:0]  RATE_1024 = 2'd0;
    localparam logic [1:0]  RATE_16   = 2'd1;
    localparam logic [1:0]  RATE_64   = 2'd2;
    localparam logic [1:0]  RATE_128  = 2'd3;

    // One input item.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] reg_addr;
        logic [7:0]  write_data;
    } hct_item_t;

    // One result item.
    typedef struct packed {
        logic [7:0] read_data;
        logic       bad_register;
    } hct_result_t;

    // Stepper period minus one for a rate code.
    function automatic logic [9:0] period_mask(input logic [1:0] rate);
        logic [9:0] mask;
        case (rate)
            RATE_1024: mask = 10'd1023;
            RATE_16:   mask = 10'd15;
            RATE_64:   mask = 10'd63;
            RATE_128:  mask = 10'd127;
            default:   mask = 10'd1023;
        endcase
        return mask;
    endfunction

endpackage

### rtl/hct_regs.sv
// Timer state registers, tick counting and register access decode.
module hct_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_en,
    input  hct_pkg::hct_item_t item,
    output hct_pkg::hct_result_t result
);
    import hct_pkg::*;

    logic [9:0] tick_count_reg, tick_count_next;
    logic [7:0] divider_reg, divider_next;
    logic [7:0] stepper_reg, stepper_next;
    logic [7:0] wrap_rounds_reg, wrap_rounds_next;
    logic       timer_on_reg, timer_on_next;
    logic [1:0] rate_code_reg, rate_code_next;

    logic [9:0] tick_inc;
    logic       div_bump;
    logic       step_bump;

    // Tick arithmetic: the divider and stepper bump on period boundaries.
    assign tick_inc  = tick_count_reg + 10'd1;
    assign div_bump  = (tick_inc & DIV_PERIOD_MASK) == 10'd0;
    assign step_bump = timer_on_reg && ((tick_inc & period_mask(rate_code_reg)) == 10'd0);

    // Next state for the item being processed.
    always_comb begin
        tick_count_next  = tick_count_reg;
        divider_next     = divider_reg;
        stepper_next     = stepper_reg;
        wrap_rounds_next = wrap_rounds_reg;
        timer_on_next    = timer_on_reg;
        rate_code_next   = rate_code_reg;
        if (item.func == FUNC_WRITE) begin
            unique case (item.reg_addr)
                ADDR_DIV:  divider_next = 8'd0;
                ADDR_STEP: stepper_next = item.write_data;
                ADDR_RND:  wrap_rounds_next = item.write_data;
                ADDR_CTRL: begin
                    timer_on_next  = item.write_data[CTRL_ENABLE_BIT];
                    rate_code_next = item.write_data[1:0];
                end
                default: ;
            endcase
        end else if (item.func == FUNC_TICK) begin
            tick_count_next = tick_inc;
            if (div_bump) begin
                divider_next = divider_reg + 8'd1;
            end
            if (step_bump) begin
                stepper_next = stepper_reg + 8'd1;
                // A wrap of the stepper counts one round.
                if (stepper_reg == 8'hFF) begin
                    wrap_rounds_next = wrap_rounds_reg + 8'd1;
                end
            end
        end
    end

    // Result of the item, from the state before it.
    always_comb begin
        result = '0;
        if (item.func == FUNC_READ) begin
            unique case (item.reg_addr)
                ADDR_DIV:  result.read_data = divider_reg;
                ADDR_STEP: result.read_data = stepper_reg;
                ADDR_RND:  result.read_data = wrap_rounds_reg;
                ADDR_CTRL: result.read_data = {5'd0, timer_on_reg, rate_code_reg};
                default: begin
                    result.read_data    = READ_UNKNOWN;
                    result.bad_register = 1'b1;
                end
            endcase
        end else if (item.func == FUNC_WRITE) begin
            if (item.reg_addr != ADDR_DIV && item.reg_addr != ADDR_STEP &&
                item.reg_addr != ADDR_RND && item.reg_addr != ADDR_CTRL) begin
                result.bad_register = 1'b1;
            end
        end
    end

    // State update, once per processed item.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_count_reg  <= '0;
            divider_reg     <= '0;
            stepper_reg     <= '0;
            wrap_rounds_reg <= '0;
            timer_on_reg    <= 1'b0;
            rate_code_reg   <= RATE_1024;
        end else if (item_en) begin
            tick_count_reg  <= tick_count_next;
            divider_reg     <= divider_next;
            stepper_reg     <= stepper_next;
            wrap_rounds_reg <= wrap_rounds_next;
            timer_on_reg    <= timer_on_next;
            rate_code_reg   <= rate_code_next;
        end
    end

endmodule

### rtl/handheld_console_timer.sv
// Top level of the handheld console timer: input register, timer state, result register.
// Each item passes the input register; its result feeds the m_ side from the result register.
// Throughput: one item per cycle while m_ready is high; the input and result registers form a
// two-stage pipeline, and the state registers update as an item moves into the result register.
// Reset (aresetn low, synchronous) clears both pipeline valids, all counters, the enable
// and the rate code.
module handheld_console_timer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [15:0] s_reg_addr,
    input  logic [7:0]  s_write_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic        m_bad_register
);
    import hct_pkg::*;

    logic        in_valid_reg;
    hct_item_t   in_item_reg;
    logic        out_valid_reg;
    hct_result_t out_result_reg;
    hct_result_t result;
    logic        advance;

    // The stage moves forward when the result register is free or being drained.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Timer state and register decode.
    hct_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{func: s_func, reg_addr: s_reg_addr, write_data: s_write_data};
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_read_data    = out_result_reg.read_data;
    assign m_bad_register = out_result_reg.bad_register;

endmodule

### tb/handheld_console_timer_tb.sv
// Self-checking testbench for the handheld console timer: random bus traffic, ticks and stalls.
module handheld_console_timer_tb;
    import hct_pkg::*;

    // Operation code with no effect; the package leaves it unnamed.
    localparam logic [1:0] FUNC_NONE = 2'd3;

    logic        aclk           = 1'b0;
    logic        aresetn        = 1'b0;
    logic        s_valid        = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func         = FUNC_READ;
    logic [15:0] s_reg_addr     = 16'h0000;
    logic [7:0]  s_write_data   = 8'h00;
    logic        m_valid;
    logic        m_ready        = 1'b0;
    logic [7:0]  m_read_data;
    logic        m_bad_register;

    // Transfers seen at the last rising edge.
    logic s_fire = 1'b0;
    logic m_fire = 1'b0;

    // Stretches in which neither side idles.
    logic calm     = 1'b0;
    int   calm_ctr = 0;
    int   gap_left   = 0;
    int   stall_left = 0;

    // Bus items waiting to be driven, and responses the timer owes.
    hct_item_t   bus_item_q[$];
    hct_result_t bus_resp_q[$];

    // Shadow copy of the timer state.
    logic [9:0] tick_ctr;
    logic [7:0] div_q;
    logic [7:0] step_q;
    logic [7:0] rounds_q;
    logic       enable_q;
    logic [1:0] rate_q;

    int n_items    = 0;
    int n_accepted = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_ticks    = 0;
    int n_reads    = 0;
    int n_writes   = 0;
    int n_unknown  = 0;
    int n_wraps    = 0;

    handheld_console_timer u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_reg_addr    (s_reg_addr),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_bad_register(m_bad_register)
    );

    always #4 aclk = ~aclk;

    // Stepper period minus one for each rate code.
    function automatic logic [9:0] rate_period(input logic [1:0] rate);
        case (rate)
            RATE_16:  return 10'd15;
            RATE_64:  return 10'd64 - 10'd1;
            RATE_128: return 10'd127;
            default:  return 10'd1023;
        endcase
    endfunction

    function automatic logic is_timer_addr(input logic [15:0] addr);
        return (addr == ADDR_DIV) || (addr == ADDR_STEP) ||
               (addr == ADDR_RND) || (addr == ADDR_CTRL);
    endfunction

    // Applies one bus item to the shadow state and returns the response it should produce.
    task automatic timer_step(input hct_item_t it, output hct_result_t res);
        res.read_data    = 8'h00;
        res.bad_register = 1'b0;
        case (it.func)
            FUNC_READ: begin
                case (it.reg_addr)
                    ADDR_DIV:  res.read_data = div_q;
                    ADDR_STEP: res.read_data = step_q;
                    ADDR_RND:  res.read_data = rounds_q;
                    ADDR_CTRL: begin
                        res.read_data = {5'b0, enable_q, rate_q};
                    end
                    default: begin
                        res.read_data    = READ_UNKNOWN;
                        res.bad_register = 1'b1;
                    end
                endcase
            end
            FUNC_WRITE: begin
                case (it.reg_addr)
                    ADDR_DIV:  div_q    = 8'h00;
                    ADDR_STEP: step_q   = it.write_data;
                    ADDR_RND:  rounds_q = it.write_data;
                    ADDR_CTRL: begin
                        enable_q = it.write_data[CTRL_ENABLE_BIT];
                        rate_q   = it.write_data[1:0];
                    end
                    default:   res.bad_register = 1'b1;
                endcase
            end
            FUNC_TICK: begin
                tick_ctr = tick_ctr + 10'd1;
                if ((tick_ctr & DIV_PERIOD_MASK) == 10'd0) begin
                    div_q = div_q + 8'd1;
                end
                if (enable_q && ((tick_ctr & rate_period(rate_q)) == 10'd0)) begin
                    step_q = step_q + 8'd1;
                    if (step_q == 8'h00) begin
                        rounds_q = rounds_q + 8'd1;
                        n_wraps++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_item(input logic [1:0] func, input logic [15:0] addr,
                             input logic [7:0] data);
        hct_item_t it;
        it.func       = func;
        it.reg_addr   = addr;
        it.write_data = data;
        bus_item_q.push_back(it);
    endtask

    // Alternates between stretches with idling and stretches without.
    always @(negedge aclk) begin
        if (calm_ctr == 0) begin
            calm     <= ($urandom_range(0, 3) == 0);
            calm_ctr <= $urandom_range(40, 300);
        end else begin
            calm_ctr <= calm_ctr - 1;
        end
    end

    // Input driver: presents the next item after its drawn gap, holds it until the transfer.
    always @(negedge aclk) begin
        hct_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left != 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (bus_item_q.size() != 0) begin
                it = bus_item_q.pop_front();
                s_func       <= it.func;
                s_reg_addr   <= it.reg_addr;
                s_write_data <= it.write_data;
                s_valid      <= 1'b1;
                gap_left     <= calm ? 0 : $urandom_range(0, 6);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result side: after each transfer, drop ready for a drawn number of cycles.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (!m_ready || m_fire) begin
            if (stall_left != 0) begin
                m_ready    <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_ready    <= 1'b1;
                stall_left <= calm ? 0 : $urandom_range(0, 6);
            end
        end
    end

    // Monitor: checks each result transfer, then predicts each input transfer.
    always @(posedge aclk) begin
        hct_item_t   it;
        hct_result_t want;
        s_fire <= aresetn && s_valid && s_ready;
        m_fire <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (bus_resp_q.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10) begin
                        $display("ERROR: unexpected result read_data=%h bad_register=%b",
                                 m_read_data, m_bad_register);
                    end
                end else begin
                    want = bus_resp_q.pop_front();
                    n_checked++;
                    if (m_read_data !== want.read_data ||
                        m_bad_register !== want.bad_register) begin
                        n_errors++;
                        if (n_errors <= 10) begin
                            $display("ERROR: result %0d expected read_data=%h bad=%b, got %h %b",
                                     n_checked, want.read_data, want.bad_register,
                                     m_read_data, m_bad_register);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                it.func       = s_func;
                it.reg_addr   = s_reg_addr;
                it.write_data = s_write_data;
                timer_step(it, want);
                bus_resp_q.push_back(want);
                n_accepted++;
                if (s_func == FUNC_TICK) n_ticks++;
                if (s_func == FUNC_READ) n_reads++;
                if (s_func == FUNC_WRITE) n_writes++;
                if ((s_func == FUNC_READ || s_func == FUNC_WRITE) &&
                    !is_timer_addr(s_reg_addr)) n_unknown++;
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        int          kind;
        int          runs;
        logic [15:0] addr;
        logic [7:0]  data;

        tick_ctr = 10'd0;
        div_q    = 8'h00;
        step_q   = 8'h00;
        rounds_q = 8'h00;
        enable_q = 1'b0;
        rate_q   = RATE_1024;

        // Directed: reset values, unknown addresses, control masking, wraps, divider clear.
        push_item(FUNC_READ,  ADDR_DIV,  8'h00);
        push_item(FUNC_READ,  ADDR_STEP, 8'h00);
        push_item(FUNC_READ,  ADDR_RND,  8'h00);
        push_item(FUNC_READ,  ADDR_CTRL, 8'h00);
        push_item(FUNC_READ,  16'h0000,  8'h00);
        push_item(FUNC_READ,  16'hFFFF,  8'hFF);
        push_item(FUNC_WRITE, 16'hFF08,  8'hFF);
        push_item(FUNC_WRITE, 16'hFF03,  8'h5A);
        push_item(FUNC_WRITE, ADDR_CTRL, 8'hFD);
        push_item(FUNC_READ,  ADDR_CTRL, 8'h00);
        push_item(FUNC_WRITE, ADDR_STEP, 8'hFF);
        push_item(FUNC_WRITE, ADDR_RND,  8'hFF);
        // Ticks ignore address and data; sixteen of them wrap both counters.
        for (int i = 0; i < 16; i++) begin
            push_item(FUNC_TICK, (i % 2) ? ADDR_DIV : 16'h0000, (i % 2) ? 8'hFF : 8'h00);
        end
        push_item(FUNC_READ,  ADDR_STEP, 8'h00);
        push_item(FUNC_READ,  ADDR_RND,  8'h00);
        push_item(FUNC_WRITE, ADDR_CTRL, 8'h07);
        push_item(FUNC_READ,  ADDR_CTRL, 8'h00);
        push_item(FUNC_WRITE, ADDR_DIV,  8'hAB);
        push_item(FUNC_READ,  ADDR_DIV,  8'h00);
        push_item(FUNC_NONE,  ADDR_STEP, 8'hFF);
        push_item(FUNC_READ,  ADDR_STEP, 8'h00);
        push_item(FUNC_WRITE, ADDR_CTRL, 8'h02);
        push_item(FUNC_READ,  ADDR_CTRL, 8'h00);
        push_item(FUNC_TICK,  16'hFFFF,  8'hFF);
        push_item(FUNC_WRITE, ADDR_CTRL, 8'h00);

        // Random: mostly runs of ticks between register accesses.
        runs = 0;
        while (runs < 860) begin
            kind = $urandom_range(0, 99);
            data = 8'($urandom);
            if (kind < 40) begin
                for (int i = $urandom_range(1, 20); i > 0; i--) begin
                    push_item(FUNC_TICK, 16'($urandom), 8'($urandom));
                    runs++;
                end
            end else begin
                if (kind < 65) begin
                    push_item(FUNC_READ, 16'(ADDR_DIV + $urandom_range(0, 3)), data);
                end else if (kind < 73) begin
                    // Keep the timer enabled most of the time.
                    data[CTRL_ENABLE_BIT] = ($urandom_range(0, 3) != 0);
                    push_item(FUNC_WRITE, ADDR_CTRL, data);
                end else if (kind < 81) begin
                    // Values near the top make wraps reachable.
                    if ($urandom_range(0, 1)) data[7:4] = 4'hF;
                    push_item(FUNC_WRITE, ADDR_STEP, data);
                end else if (kind < 85) begin
                    push_item(FUNC_WRITE, ADDR_RND, data);
                end else if (kind < 88) begin
                    push_item(FUNC_WRITE, ADDR_DIV, data);
                end else if (kind < 96) begin
                    addr = $urandom_range(0, 1) ? 16'($urandom)
                                                : 16'(16'hFF00 + $urandom_range(0, 15));
                    push_item($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ, addr, data);
                end else begin
                    push_item(FUNC_NONE, 16'($urandom), data);
                end
                runs++;
            end
        end
        n_items = bus_item_q.size();

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (n_accepted < n_items) @(posedge aclk);
        while (bus_resp_q.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Run covered %0d items: %0d ticks, %0d reads, %0d writes, %0d unknown addresses.",
                 n_accepted, n_ticks, n_reads, n_writes, n_unknown);
        $display("Checked %0d results; stepper wrapped %0d times; %0d mismatches.",
                 n_checked, n_wraps, n_errors);
        if (n_errors == 0 && bus_resp_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(8 * 300000);
        $display("TEST FAILED");
        $finish;
    end

endmodule

### handheld_console_timer.f
rtl/hct_pkg.sv
rtl/hct_regs.sv
rtl/handheld_console_timer.sv
tb/handheld_console_timer_tb.sv
